// ----- rtl/core/ipfc_pkg.sv -----
// Shared types, constants and the bytewise CRC-32 step of the packet framer.
package ipfc_pkg;

  localparam int unsigned POS_W = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] START_RESET = 32'hFE81_FF55;

  localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(4);
  localparam logic [POS_W-1:0] WORDS_END = POS_W'(32);
  localparam logic [POS_W-1:0] STATUS_POS = POS_W'(32);
  localparam logic [POS_W-1:0] SEQ_POS = POS_W'(33);
  localparam int unsigned NUM_WORDS = 7;

  // One received byte and its place in the packet, sent from front to back.
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } tok_t;

  typedef struct packed {
    logic [31:0] gyro_x;
    logic [31:0] gyro_y;
    logic [31:0] gyro_z;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
    logic [31:0] aux_word;
    logic [1:0]  aux_kind;
    logic [5:0]  status_bits;
    logic [7:0]  sequence_res;
    logic        crc_ok;
  } res_t;

  // MSB-first CRC-32 update with one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/imu_packet_framer_crc_check.sv -----
// Top level of the IMU packet framer with CRC-32 check.
//
//  channel    direction  request                     payload
//  s_axis     in         one received byte           tdata[7:0] rx_byte
//  m_axis     out        one decoded packet          tdata: sensor words, status, sequence
//                                                    tuser: aux_kind, crc_ok
//  cfg        in         start word write            cfg_wdata_i, taken when cfg_we_i
//
// The block takes one byte every cycle while the queue has room; bytes flow through a two-entry queue.
// The back end runs the CRC update at one byte per cycle while it is not stalled, and that sets the rate.
// The last byte of a packet passes through the queue, and its result is then written to the result register.
// Reset restores the start word to FE81FF55 and restarts the hunt.
// Either side may stall; the queue and the result register let the other keep going.
module imu_packet_framer_crc_check #(
  parameter int unsigned PACKET_BYTES = 38
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Start word, first expected byte in the top eight bits.
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] rx_byte
  input  logic [7:0]   s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] gyro_x, [63:32] gyro_y, [95:64] gyro_z, [127:96] accel_x,
  // [159:128] accel_y, [191:160] accel_z, [223:192] aux_word,
  // [229:224] status_bits, [237:230] sequence_res, [239:238] zero
  output logic [239:0] m_axis_tdata,
  // [1:0] aux_kind, [2] crc_ok
  output logic [2:0]   m_axis_tuser
);
  import ipfc_pkg::*;

  tok_t fr_tok, bk_tok;
  logic fr_valid, q_not_full, q_valid, bk_ready;
  res_t res;

  // The front end sorts each byte into header or body and tags its position.
  ipfc_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .tok_valid_o (fr_valid),
    .tok_ready_i (q_not_full),
    .tok_o       (fr_tok)
  );

  ipfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid),
    .not_full_o  (q_not_full),
    .push_data_i (fr_tok),
    .valid_o     (q_valid),
    .pop_i       (bk_ready),
    .pop_data_o  (bk_tok)
  );

  // The back end runs the CRC, captures the fields and holds the finished result.
  ipfc_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_ready_o (bk_ready),
    .tok_i       (bk_tok),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.sequence_res, res.status_bits, res.aux_word,
                         res.accel_z, res.accel_y, res.accel_x,
                         res.gyro_z, res.gyro_y, res.gyro_x};
  assign m_axis_tuser = {res.crc_ok, res.aux_kind};

endmodule

// ----- rtl/core/ipfc_front.sv -----
// Front end: start word hunt and byte position tracking.
module ipfc_front #(
  parameter int unsigned PACKET_BYTES = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_data_i,
  output logic                tok_valid_o,
  input  logic                tok_ready_i,
  output ipfc_pkg::tok_t      tok_o
);
  import ipfc_pkg::*;

  localparam logic [POS_W-1:0] LastPos = POS_W'(PACKET_BYTES - 1);

  logic [31:0]      start_word_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       want;
  logic             collecting, match, accept;

  always_comb begin
    case (pos_q[1:0])
      2'd0:    want = start_word_q[31:24];
      2'd1:    want = start_word_q[23:16];
      2'd2:    want = start_word_q[15:8];
      default: want = start_word_q[7:0];
    endcase
  end

  assign collecting = (pos_q >= HDR_BYTES);
  assign match      = (in_data_i == want);
  assign in_ready_o = tok_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (collecting) begin
        pos_d = (pos_q == LastPos) ? '0 : pos_q + POS_W'(1);
      end else begin
        // A mismatching header byte is dropped and the hunt restarts.
        pos_d = match ? pos_q + POS_W'(1) : '0;
      end
    end
  end

  assign tok_valid_o = accept && (collecting || match);
  assign tok_o.data  = in_data_i;
  assign tok_o.pos   = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_q <= START_RESET;
      pos_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        start_word_q <= cfg_wdata_i;
      end
      pos_q <= pos_d;
    end
  end

endmodule

// ----- rtl/core/ipfc_queue.sv -----
// Small register FIFO between the front end and the back end.
module ipfc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           not_full_o,
  input  ipfc_pkg::tok_t push_data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output ipfc_pkg::tok_t pop_data_o
);
  import ipfc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  tok_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign not_full_o = (count_q != FullCnt);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && not_full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count above depth");

  a_push_never_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> not_full_o)
    else $error("token pushed into a full queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FullCnt) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/core/ipfc_back.sv -----
// Back end: running CRC, field capture and the result register.
module ipfc_back #(
  parameter int unsigned PACKET_BYTES = 38
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tok_valid_i,
  output logic           tok_ready_o,
  input  ipfc_pkg::tok_t tok_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output ipfc_pkg::res_t res_o
);
  import ipfc_pkg::*;

  localparam logic [POS_W-1:0] LastPos = POS_W'(PACKET_BYTES - 1);
  localparam logic [POS_W-1:0] CrcPos  = POS_W'(PACKET_BYTES - 4);

  logic [31:0]      words_q [NUM_WORDS];
  logic [7:0]       status_q, seq_q;
  logic [31:0]      sent_q, crc_q, crc_d, sent_full;
  logic [POS_W-1:0] pos_m4;
  logic [2:0]       widx;
  logic             is_last, pop, out_valid_q;
  res_t             res_q, res_d;

  assign is_last     = (tok_i.pos == LastPos);
  assign tok_ready_o = !is_last || !out_valid_q || res_ready_i;
  assign pop         = tok_valid_i && tok_ready_o;
  assign pos_m4      = tok_i.pos - HDR_BYTES;
  assign widx        = pos_m4[4:2];
  assign sent_full   = {sent_q[23:0], tok_i.data};

  always_comb begin
    crc_d = crc_q;
    if (tok_i.pos == '0) begin
      crc_d = crc_byte(CRC_INIT, tok_i.data);
    end else if (tok_i.pos < CrcPos) begin
      crc_d = crc_byte(crc_q, tok_i.data);
    end
  end

  always_comb begin
    res_d.gyro_x       = words_q[0];
    res_d.gyro_y       = words_q[1];
    res_d.gyro_z       = words_q[2];
    res_d.accel_x      = words_q[3];
    res_d.accel_y      = words_q[4];
    res_d.accel_z      = words_q[5];
    res_d.aux_word     = words_q[6];
    res_d.aux_kind     = seq_q[1:0];
    res_d.status_bits  = {status_q[6:4], status_q[2:0]};
    res_d.sequence_res = seq_q;
    res_d.crc_ok       = (sent_full == crc_q);
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (tok_i.pos >= HDR_BYTES && tok_i.pos < WORDS_END) begin
        words_q[widx] <= {words_q[widx][23:0], tok_i.data};
      end
      if (tok_i.pos == STATUS_POS) begin
        status_q <= tok_i.data;
      end
      if (tok_i.pos == SEQ_POS) begin
        seq_q <= tok_i.data;
      end
      if (tok_i.pos >= CrcPos) begin
        sent_q <= sent_full;
      end
      if (is_last) begin
        res_q <= res_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        crc_q <= crc_d;
      end
      if (pop && is_last) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- sim/imu_packet_framer_crc_check_tb.sv -----
// Self-checking testbench for the IMU packet framer: byte stream in, checked packets out.
`timescale 1ns / 100ps

module imu_packet_framer_crc_check_tb;

  localparam int unsigned FRAME_LEN = 38;
  localparam int unsigned CRC_END = FRAME_LEN - 4;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned FRAMES_PER_PHASE = 9;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef enum int {
    NOISE_RANDOM,
    NOISE_BAD_TAIL,
    NOISE_RESTART
  } noise_e;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  imu_packet_framer_crc_check #(
    .PACKET_BYTES(FRAME_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Bytes waiting to be sent and decoded packets waiting to come out.
  logic [7:0]      tx_bytes[$];
  ipfc_pkg::res_t  pending_frames[$];

  // Framer state as the testbench tracks it.
  logic [31:0]     sync_word = ipfc_pkg::START_RESET;
  int unsigned     sync_idx = 0;
  int unsigned     body_len = 0;
  logic [7:0]      frame_buf[FRAME_LEN];
  logic [31:0]     run_crc = ipfc_pkg::CRC_INIT;

  int unsigned     err_cnt = 0;
  int unsigned     cycle_cnt = 0;
  bit              calm = 1'b0;
  logic            hold_go = 1'b0;
  logic            hold_done = 1'b0;
  int unsigned     hold_cnt = 0;
  wire             sink_hold = hold_go && !hold_done;

  // MSB-first CRC-32 update, one input bit at a time.
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[31] ^ b[i];
      r = {r[30:0], 1'b0} ^ (fb ? ipfc_pkg::CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  function automatic logic [31:0] word_from(input int unsigned p);
    return {frame_buf[p], frame_buf[p+1], frame_buf[p+2], frame_buf[p+3]};
  endfunction

  // Appends one byte to the send queue.
  task automatic tx_add(input logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endtask

  // Advances the tracked framer by one accepted byte and records a packet when it completes.
  task automatic frame_byte(input logic [7:0] b);
    int unsigned    pos;
    ipfc_pkg::res_t r;
    if (sync_idx < 4) begin
      if (b == sync_word[(31 - 8*sync_idx) -: 8]) begin
        frame_buf[sync_idx] = b;
        run_crc = crc32_step(run_crc, b);
        sync_idx++;
      end else begin
        sync_idx = 0;
        body_len = 0;
        run_crc = ipfc_pkg::CRC_INIT;
      end
    end else begin
      pos = 4 + body_len;
      frame_buf[pos] = b;
      if (pos < CRC_END) begin
        run_crc = crc32_step(run_crc, b);
      end
      body_len++;
      if (pos + 1 == FRAME_LEN) begin
        r.gyro_x = word_from(4);
        r.gyro_y = word_from(8);
        r.gyro_z = word_from(12);
        r.accel_x = word_from(16);
        r.accel_y = word_from(20);
        r.accel_z = word_from(24);
        r.aux_word = word_from(28);
        r.aux_kind = frame_buf[33][1:0];
        r.status_bits = {frame_buf[32][6:4], frame_buf[32][2:0]};
        r.sequence_res = frame_buf[33];
        r.crc_ok = (word_from(CRC_END) == run_crc);
        pending_frames.insert(pending_frames.size(), r);
        sync_idx = 0;
        body_len = 0;
        run_crc = ipfc_pkg::CRC_INIT;
      end
    end
  endtask

  // Builds one packet behind the given header; a bad one has a single bit flipped after the header.
  task automatic queue_frame(input logic [31:0] hdr, input bit good, input fill_e fill);
    logic [7:0]  f[FRAME_LEN];
    logic [31:0] c;
    int unsigned k;
    int unsigned bitn;
    c = ipfc_pkg::CRC_INIT;
    for (k = 0; k < 4; k++) begin
      f[k] = hdr[(31 - 8*k) -: 8];
    end
    for (k = 4; k < CRC_END; k++) begin
      case (fill)
        FILL_ZERO: f[k] = 8'h00;
        FILL_ONES: f[k] = 8'hFF;
        default:   f[k] = 8'($urandom_range(255));
      endcase
    end
    for (k = 0; k < CRC_END; k++) begin
      c = crc32_step(c, f[k]);
    end
    for (k = 0; k < 4; k++) begin
      f[CRC_END + k] = c[(31 - 8*k) -: 8];
    end
    if (!good) begin
      k = $urandom_range(FRAME_LEN - 1, 4);
      bitn = $urandom_range(7);
      f[k][bitn] = ~f[k][bitn];
    end
    for (k = 0; k < FRAME_LEN; k++) begin
      tx_add(f[k]);
    end
  endtask

  // Line garbage between packets: stray bytes, or a header that breaks off part way.
  task automatic queue_noise(input logic [31:0] hdr);
    noise_e      kind;
    int unsigned n;
    kind = noise_e'($urandom_range(2));
    n = $urandom_range(3, 1);
    case (kind)
      NOISE_RANDOM: begin
        repeat (n) tx_add(8'($urandom_range(255)));
      end
      NOISE_BAD_TAIL: begin
        for (int k = 0; k < n; k++) tx_add(hdr[(31 - 8*k) -: 8]);
        tx_add(hdr[(31 - 8*n) -: 8] ^ 8'($urandom_range(255, 1)));
      end
      default: begin
        // The breaking byte is the first header byte, which must not restart the hunt.
        for (int k = 0; k < n; k++) tx_add(hdr[(31 - 8*k) -: 8]);
        tx_add(hdr[31:24]);
      end
    endcase
  endtask

  task automatic drain;
    while (tx_bytes.size() != 0 || s_axis_tvalid || pending_frames.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endtask

  // Sender: tracks every accepted byte, then offers the next one unless it idles this cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_byte(s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_bytes.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= tx_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // The long receiver hold-off runs once, counted here.
  always @(posedge clk_i) begin
    if (sink_hold) begin
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Receiver: compares each accepted packet with the oldest one predicted.
  always @(posedge clk_i) begin : sink_side
    ipfc_pkg::res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_frames.size() == 0) begin
          $error("packet result with none predicted");
          err_cnt++;
        end else begin
          want = pending_frames.pop_front();
          check_field("gyro_x", want.gyro_x, m_axis_tdata[31:0]);
          check_field("gyro_y", want.gyro_y, m_axis_tdata[63:32]);
          check_field("gyro_z", want.gyro_z, m_axis_tdata[95:64]);
          check_field("accel_x", want.accel_x, m_axis_tdata[127:96]);
          check_field("accel_y", want.accel_y, m_axis_tdata[159:128]);
          check_field("accel_z", want.accel_z, m_axis_tdata[191:160]);
          check_field("aux_word", want.aux_word, m_axis_tdata[223:192]);
          check_field("status_bits", 32'(want.status_bits), 32'(m_axis_tdata[229:224]));
          check_field("sequence_res", 32'(want.sequence_res), 32'(m_axis_tdata[237:230]));
          check_field("aux_kind", 32'(want.aux_kind), 32'(m_axis_tuser[1:0]));
          check_field("crc_ok", 32'(want.crc_ok), 32'(m_axis_tuser[2]));
        end
      end
      m_axis_tready <= !sink_hold && (calm || $urandom_range(99) >= 22);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] words[5];
    words[0] = ipfc_pkg::START_RESET;
    words[1] = 32'h0000_0000;
    words[2] = 32'hFFFF_FFFF;
    words[3] = $urandom;
    words[4] = 32'h6666_6666;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        @(posedge clk_i);
        cfg_we_i <= 1'b1;
        cfg_wdata_i <= words[ph];
        sync_word = words[ph];
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      // The second setting runs with both sides at full rate; the third starts with the long hold-off.
      calm = (ph == 1);
      if (ph == 2) begin
        hold_go <= 1'b1;
      end
      if (ph == 0) begin
        // Header that fails on its last byte, then a repeated first byte that is dropped.
        tx_add(8'hFE);
        tx_add(8'h81);
        tx_add(8'hFF);
        tx_add(8'h00);
        tx_add(8'hFE);
        tx_add(8'hFE);
        tx_add(8'h81);
        queue_frame(words[0], 1'b1, FILL_ONES);
        queue_frame(words[0], 1'b0, FILL_ZERO);
        queue_frame(words[0], 1'b1, FILL_ZERO);
        queue_frame(words[0], 1'b0, FILL_ONES);
      end
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if ($urandom_range(3) == 0) begin
          queue_noise(words[ph]);
        end
        queue_frame(words[ph], $urandom_range(99) < 80, FILL_RANDOM);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
